FILE: rtl/daff_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// daff_pkg: shared types and codes for the device affinity table
// Item structs for both channels, status and op codes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package daff_pkg;

    // op codes of an input item
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // result status codes
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam int KEY_W = 64;
    localparam int IDX_W = 6;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] device_key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] worker_index;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic start;   // lookup accepted: latch key, run pending sweep
        logic tick;    // tick accepted: mark sweep pending
        logic scan;    // step the slot scan
        logic commit;  // update table, load result register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } t_dp_sts;

endpackage : daff_pkg
`default_nettype wire

FILE: rtl/daff_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// daff_ctrl: sequencer for the device affinity table
// Accepts items while idle, steps the datapath through scan and commit, and
// owns the valid bit of the result register.
// ----------------------------------------------------------------------------
module daff_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_op,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output daff_pkg::t_dp_cmd     o_cmd,
    input  wire daff_pkg::t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   in_acc;
    logic   can_load;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign can_load    = !r_out_vld || !i_out_stall;

    // issue datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.start  = in_acc && (i_in_op == daff_pkg::OP_LOOKUP);
        o_cmd.tick   = in_acc && (i_in_op == daff_pkg::OP_TICK);
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_FINISH) && can_load;
    end

    // advance the state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (can_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // set on load, drop when the item is taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.commit) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule : daff_ctrl
`default_nettype wire

FILE: rtl/daff_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// daff_dpath: slot store, aging sweep and scan logic
// Holds the key memory, used and touched bits and the sweep flag. A scan
// reads one key per cycle and compares it in the next cycle, tracking the
// first hit and the lowest free slot.
// ----------------------------------------------------------------------------
module daff_dpath #(
    parameter int WORKERS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire daff_pkg::t_dp_cmd             i_cmd,
    output daff_pkg::t_dp_sts                  o_sts,
    input  wire logic [daff_pkg::KEY_W-1:0]    i_key,
    output daff_pkg::t_out_item                o_out_item
);

    localparam int SLOTS = 2 * WORKERS;
    localparam int SW    = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST_IDX  = SW'(SLOTS - 1);
    localparam logic [SW-1:0] WORKERS_W = SW'(WORKERS);

    logic [daff_pkg::KEY_W-1:0] mem_key [SLOTS];

    logic [SLOTS-1:0]           r_used;
    logic [SLOTS-1:0]           r_touched;
    logic                       r_pending;
    logic [daff_pkg::KEY_W-1:0] r_key;
    logic [SW-1:0]              r_rd_idx;
    logic                       r_rd_run;
    logic [daff_pkg::KEY_W-1:0] r_rd_key;
    logic [SW-1:0]              r_cmp_idx;
    logic                       r_cmp_vld;
    logic                       r_hit;
    logic [SW-1:0]              r_hit_idx;
    logic                       r_have_free;
    logic [SW-1:0]              r_free_idx;
    daff_pkg::t_out_item        r_out_item;

    logic                       cmp_used;
    logic                       cmp_match;
    logic [SW-1:0]              sel_slot;
    logic [SW-1:0]              sel_mod;
    daff_pkg::t_out_item        res_item;

    assign cmp_used        = r_used[r_cmp_idx];
    assign cmp_match       = (r_rd_key == r_key);
    assign o_sts.scan_done = r_cmp_vld && (r_cmp_idx == LAST_IDX);
    assign o_out_item      = r_out_item;

    // fold slot number onto worker index
    always_comb begin
        sel_slot = r_hit ? r_hit_idx : r_free_idx;
        sel_mod  = (sel_slot >= WORKERS_W) ? (sel_slot - WORKERS_W) : sel_slot;
        priority if (r_hit) begin
            res_item.status       = daff_pkg::ST_FOUND;
            res_item.worker_index = daff_pkg::IDX_W'(sel_mod);
        end else if (r_have_free) begin
            res_item.status       = daff_pkg::ST_INSERTED;
            res_item.worker_index = daff_pkg::IDX_W'(sel_mod);
        end else begin
            res_item.status       = daff_pkg::ST_FULL;
            res_item.worker_index = '0;
        end
    end

    // key memory: one read per scan step, one write at commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && r_rd_run) begin
            r_rd_key <= mem_key[r_rd_idx];
        end
        if (i_cmd.commit && !r_hit && r_have_free) begin
            mem_key[r_free_idx] <= r_key;
        end
    end

    // latch key and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= i_key;
        end
        if (i_cmd.commit) begin
            r_out_item <= res_item;
        end
        if (i_cmd.scan && r_rd_run) begin
            r_cmp_idx <= r_rd_idx;
        end
    end

    // slot state, sweep flag and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_touched   <= '0;
            r_pending   <= 1'b0;
            r_rd_idx    <= '0;
            r_rd_run    <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_hit_idx   <= '0;
            r_have_free <= 1'b0;
            r_free_idx  <= '0;
        end else begin
            if (i_cmd.tick) begin
                r_pending <= 1'b1;
            end

            // start: run pending sweep, reset scan
            if (i_cmd.start) begin
                if (r_pending) begin
                    r_used    <= r_used & r_touched;
                    r_touched <= '0;
                    r_pending <= 1'b0;
                end
                r_rd_idx    <= '0;
                r_rd_run    <= 1'b1;
                r_cmp_vld   <= 1'b0;
                r_hit       <= 1'b0;
                r_have_free <= 1'b0;
            end

            // step read address
            if (i_cmd.scan) begin
                r_cmp_vld <= r_rd_run;
                if (r_rd_run) begin
                    if (r_rd_idx == LAST_IDX) begin
                        r_rd_run <= 1'b0;
                    end else begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                end
            end

            // compare one slot
            if (i_cmd.scan && r_cmp_vld) begin
                if (cmp_used) begin
                    if (!r_hit && cmp_match) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_cmp_idx;
                    end
                end else if (!r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= r_cmp_idx;
                end
            end

            // commit: touch on hit, claim slot on insert
            if (i_cmd.commit) begin
                if (r_hit) begin
                    r_touched[r_hit_idx] <= 1'b1;
                end else if (r_have_free) begin
                    r_used[r_free_idx]    <= 1'b1;
                    r_touched[r_free_idx] <= 1'b1;
                end
            end
        end
    end

endmodule : daff_dpath
`default_nettype wire

FILE: rtl/device_affinity_table_with_aging_unit.sv
`default_nettype none
// Lookup: the scan reads one slot key per cycle from the key memory; the result
//   is registered at commit, which waits while an earlier result is stalled,
//   and the next item is accepted back in idle. Tick: taken in idle, stays idle.
// The result register lets the next item enter while a result waits.
// Reset (synchronous, active low) frees all slots, clears touched marks and
//   the sweep flag at once; key memory is not cleared.
// ----------------------------------------------------------------------------
// device_affinity_table_with_aging_unit: device key to worker index map
// Table of 2*WORKERS slots with aging sweep on refresh ticks; hit, insert
// into the lowest free slot, or table full.
// ----------------------------------------------------------------------------
module device_affinity_table_with_aging_unit #(
    parameter int WORKERS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire daff_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output daff_pkg::t_out_item      o_out_item
);

    daff_pkg::t_dp_cmd cmd;
    daff_pkg::t_dp_sts sts;

    daff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_item.op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    daff_dpath #(
        .WORKERS (WORKERS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_key      (i_in_item.device_key),
        .o_out_item (o_out_item)
    );

endmodule : device_affinity_table_with_aging_unit
`default_nettype wire
